>>> hdl/double_ended_queue_defines.svh
// ----------------------------------------------------------------------------
// Double-ended queue assertion macros
// Shared assertion forms for the queue RTL, clocked on clock, off in reset.
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// The condition must hold on every clock edge outside reset.
`define DEQ_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("double_ended_queue: invariant violated");

// When pre holds, post must hold on the same edge.
`define DEQ_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("double_ended_queue: implication violated");

// When pre holds, post must hold on the next edge.
`define DEQ_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("double_ended_queue: next-cycle implication violated");

`endif

>>> hdl/deq_pkg.sv
// ----------------------------------------------------------------------------
// Double-ended queue package
// Operation and status codes, field widths and the default depth.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEPTH_DEFAULT = 16;
   localparam int VALUE_WIDTH   = 32;

   typedef enum logic [1:0] {
      OP_PUSH_REAR  = 2'd0,
      OP_PUSH_FRONT = 2'd1,
      OP_POP_REAR   = 2'd2,
      OP_POP_FRONT  = 2'd3
   } operation_type;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

endpackage

>>> hdl/deq_ram.sv
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read that holds its
// data while no read is enabled.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AddrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 write_enable,
   input  logic [AddrWidth-1:0] write_address,
   input  logic [WIDTH-1:0]     write_data,
   input  logic                 read_enable,
   input  logic [AddrWidth-1:0] read_address,
   output logic [WIDTH-1:0]     read_data
);

   logic [WIDTH-1:0] memory_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         memory_ff[write_address] <= write_data;
      end
      if (read_enable) begin
         read_data_ff <= memory_ff[read_address];
      end
   end

   assign read_data = read_data_ff;

endmodule

>>> hdl/double_ended_queue.sv
// ----------------------------------------------------------------------------
// Double-ended queue
// Bounded ring of signed values with push and pop at both ends.
// ----------------------------------------------------------------------------
// Each item asks for a push or a pop at the rear or the front and produces one
// result item with a status, the removed value and the count after the
// operation. Values live in a single RAM with a registered read; the rear
// index, front index and count live in registers. A push, or a pop or push
// that is refused, is answered in the cycle after it is accepted, and a new
// item can be taken every cycle while the result side is not stalled. A
// successful pop reads the RAM and sets a pending state; its result is
// registered from the read data once the result side is free, and the input
// stalls until then. The entries hold no reset value and need no clearing pass.
`include "double_ended_queue_defines.svh"

module double_ended_queue #(
   parameter int DEPTH = deq_pkg::DEPTH_DEFAULT,
   localparam int IndexWidth = $clog2(DEPTH),
   localparam int CountWidth = $clog2(DEPTH + 1)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_operation,
   input  logic signed [deq_pkg::VALUE_WIDTH-1:0] req_value_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_status,
   output logic signed [deq_pkg::VALUE_WIDTH-1:0] rsp_value_out,
   output logic [CountWidth-1:0]                rsp_count_after
);

   localparam logic [IndexWidth-1:0] LastIndex = IndexWidth'(DEPTH - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(DEPTH);

   deq_pkg::operation_type operation;

   logic [IndexWidth-1:0] rear_ff, rear_in;
   logic [IndexWidth-1:0] front_ff, front_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   deq_pkg::status_type   rsp_status_ff, rsp_status_in;
   logic [deq_pkg::VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic [CountWidth-1:0] rsp_count_ff, rsp_count_in;

   logic                  out_free;
   logic                  accept;
   logic                  is_push;
   logic                  is_full;
   logic                  is_empty;
   logic [IndexWidth-1:0] rear_fwd;
   logic [IndexWidth-1:0] rear_back;
   logic [IndexWidth-1:0] front_fwd;
   logic [IndexWidth-1:0] front_back;

   logic                  ram_write_enable;
   logic [IndexWidth-1:0] ram_write_address;
   logic                  ram_read_enable;
   logic [IndexWidth-1:0] ram_read_address;
   logic [deq_pkg::VALUE_WIDTH-1:0] ram_read_data;

   assign operation = deq_pkg::operation_type'(req_operation);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = pend_ff || !out_free;
   assign accept    = req_valid && !req_stall;
   assign is_push   = (operation == deq_pkg::OP_PUSH_REAR) ||
                      (operation == deq_pkg::OP_PUSH_FRONT);
   assign is_full   = (count_ff == FullCount);
   assign is_empty  = (count_ff == '0);

   assign rear_fwd   = (rear_ff == LastIndex) ? '0 : rear_ff + 1'b1;
   assign rear_back  = (rear_ff == '0) ? LastIndex : rear_ff - 1'b1;
   assign front_fwd  = (front_ff == LastIndex) ? '0 : front_ff + 1'b1;
   assign front_back = (front_ff == '0) ? LastIndex : front_ff - 1'b1;

   always_comb begin
      rear_in           = rear_ff;
      front_in          = front_ff;
      count_in          = count_ff;
      pend_in           = pend_ff;
      rsp_valid_in      = rsp_valid_ff && rsp_stall;
      rsp_status_in     = rsp_status_ff;
      rsp_value_in      = rsp_value_ff;
      rsp_count_in      = rsp_count_ff;
      ram_write_enable  = 1'b0;
      ram_write_address = rear_fwd;
      ram_read_enable   = 1'b0;
      ram_read_address  = rear_ff;

      if (pend_ff) begin
         if (out_free) begin
            pend_in       = 1'b0;
            rsp_valid_in  = 1'b1;
            rsp_status_in = deq_pkg::ST_DONE;
            rsp_value_in  = ram_read_data;
            rsp_count_in  = count_ff;
         end
      end else if (accept) begin
         rsp_value_in = '0;
         if (is_push) begin
            rsp_valid_in = 1'b1;
            if (is_full) begin
               rsp_status_in = deq_pkg::ST_FULL;
               rsp_count_in  = count_ff;
            end else begin
               rsp_status_in    = deq_pkg::ST_DONE;
               count_in         = count_ff + 1'b1;
               rsp_count_in     = count_in;
               ram_write_enable = 1'b1;
               if (operation == deq_pkg::OP_PUSH_REAR) begin
                  rear_in           = rear_fwd;
                  ram_write_address = rear_fwd;
               end else begin
                  front_in          = front_back;
                  ram_write_address = front_back;
               end
            end
         end else if (is_empty) begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = deq_pkg::ST_EMPTY;
            rsp_count_in  = count_ff;
         end else begin
            pend_in         = 1'b1;
            count_in        = count_ff - 1'b1;
            ram_read_enable = 1'b1;
            if (operation == deq_pkg::OP_POP_REAR) begin
               rear_in          = rear_back;
               ram_read_address = rear_ff;
            end else begin
               front_in         = front_fwd;
               ram_read_address = front_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rear_ff      <= '0;
         front_ff     <= IndexWidth'(1);
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rear_ff      <= rear_in;
         front_ff     <= front_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_count_ff  <= rsp_count_in;
   end

   deq_ram #(
      .WIDTH (deq_pkg::VALUE_WIDTH),
      .DEPTH (DEPTH)
   ) entries_ram (
      .clock         (clock),
      .write_enable  (ram_write_enable),
      .write_address (ram_write_address),
      .write_data    (req_value_in),
      .read_enable   (ram_read_enable),
      .read_address  (ram_read_address),
      .read_data     (ram_read_data)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_count_after = rsp_count_ff;

   `DEQ_ASSERT_ALWAYS(count_bounded_a, count_ff <= FullCount)
   `DEQ_ASSERT_SAME(pend_blocks_input_a, pend_ff, req_stall)
   `DEQ_ASSERT_NEXT(empty_pop_reported_a, accept && !is_push && is_empty, rsp_valid_ff && rsp_status_ff == deq_pkg::ST_EMPTY)
   `DEQ_ASSERT_NEXT(pop_starts_read_a, accept && !is_push && !is_empty, pend_ff && !rsp_valid_ff)
   `DEQ_ASSERT_NEXT(count_holds_when_idle_a, !accept, $stable(count_ff))

endmodule

>>> tb/double_ended_queue_tb.sv
// ----------------------------------------------------------------------------
// Double-ended queue testbench
// Drives push and pop items at both ends of the queue through the valid and
// stall handshake, with random gaps on the sender and random stalls on the
// receiver. Every result item is compared field by field against the step table's
// result or a shadow ring of sixteen entries predicting status, popped value and count.
// ----------------------------------------------------------------------------
module double_ended_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = deq_pkg::DEPTH_DEFAULT;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int COUNT_W     = $clog2(DEPTH + 1);
   localparam int ITEM_TARGET = 850;
   localparam int HOLD_CYCLES = 80;
   localparam int CYCLE_LIMIT = 200000;

   typedef struct packed {
      deq_pkg::status_type status;
      logic [31:0]         value_out;
      logic [COUNT_W-1:0]  count_after;
   } deque_result_type;

   typedef struct packed {
      deq_pkg::operation_type op;
      logic [31:0]            value;
      logic [4:0]             reps;
      logic                   typed;
      deque_result_type       res;
   } deque_step_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_operation = deq_pkg::OP_PUSH_REAR;
   logic signed [31:0]       req_value_in = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [1:0]               rsp_status;
   logic signed [31:0]       rsp_value_out;
   logic [COUNT_W-1:0]       rsp_count_after;

   logic [31:0]              shadow_entries [DEPTH];
   logic [IDX_W-1:0]         shadow_rear = '0;
   int                       shadow_count = 0;
   deque_result_type         expected_q [$];
   int                       items_sent = 0;
   int                       errors = 0;
   int                       cycle_count = 0;
   logic                     holdoff_go = 1'b0;
   logic                     holdoff_taken = 1'b0;
   int                       hold_left = 0;
   logic [1:0]               stall_mode = 2'd0;
   logic [15:0]              stall_cycle = '0;

   deque_step_type directed_steps [12] = '{
      '{deq_pkg::OP_POP_REAR,   32'h0000_0000, 5'd1, 1'b1,
        '{deq_pkg::ST_EMPTY, 32'h0000_0000, 5'd0}},
      '{deq_pkg::OP_POP_FRONT,  32'h0000_0000, 5'd1, 1'b1,
        '{deq_pkg::ST_EMPTY, 32'h0000_0000, 5'd0}},
      '{deq_pkg::OP_PUSH_REAR,  32'h7fff_ffff, 5'd1, 1'b1,
        '{deq_pkg::ST_DONE,  32'h0000_0000, 5'd1}},
      '{deq_pkg::OP_POP_FRONT,  32'h0000_0000, 5'd1, 1'b1,
        '{deq_pkg::ST_DONE,  32'h7fff_ffff, 5'd0}},
      '{deq_pkg::OP_PUSH_FRONT, 32'h8000_0000, 5'd1, 1'b1,
        '{deq_pkg::ST_DONE,  32'h0000_0000, 5'd1}},
      '{deq_pkg::OP_POP_REAR,   32'h0000_0000, 5'd1, 1'b1,
        '{deq_pkg::ST_DONE,  32'h8000_0000, 5'd0}},
      '{deq_pkg::OP_PUSH_FRONT, 32'hffff_fff0, 5'd8, 1'b0,
        '{deq_pkg::ST_DONE,  32'h0000_0000, 5'd0}},
      '{deq_pkg::OP_PUSH_REAR,  32'h5555_aaa0, 5'd8, 1'b0,
        '{deq_pkg::ST_DONE,  32'h0000_0000, 5'd0}},
      '{deq_pkg::OP_PUSH_REAR,  32'h0000_0000, 5'd1, 1'b1,
        '{deq_pkg::ST_FULL,  32'h0000_0000, 5'd16}},
      '{deq_pkg::OP_PUSH_FRONT, 32'hffff_ffff, 5'd1, 1'b1,
        '{deq_pkg::ST_FULL,  32'h0000_0000, 5'd16}},
      '{deq_pkg::OP_POP_FRONT,  32'h0000_0000, 5'd1, 1'b0,
        '{deq_pkg::ST_DONE,  32'h0000_0000, 5'd0}},
      '{deq_pkg::OP_POP_REAR,   32'ha5a5_a5a5, 5'd1, 1'b0,
        '{deq_pkg::ST_DONE,  32'h0000_0000, 5'd0}}
   };

   double_ended_queue dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_value_in    (req_value_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_value_out   (rsp_value_out),
      .rsp_count_after (rsp_count_after)
   );

   always #10 clock = ~clock;

   function automatic deque_result_type apply_operation(deq_pkg::operation_type op,
                                                        logic [31:0] v);
      deque_result_type r;
      logic [IDX_W-1:0] slot;
      r = '{deq_pkg::ST_DONE, 32'd0, '0};
      case (op)
         deq_pkg::OP_PUSH_REAR, deq_pkg::OP_PUSH_FRONT: begin
            if (shadow_count >= DEPTH) begin
               r.status = deq_pkg::ST_FULL;
            end else if (op == deq_pkg::OP_PUSH_REAR) begin
               shadow_rear = shadow_rear + 1'b1;
               shadow_entries[shadow_rear] = v;
               shadow_count++;
            end else begin
               slot = shadow_rear - IDX_W'(shadow_count);
               shadow_entries[slot] = v;
               shadow_count++;
            end
         end
         default: begin
            if (shadow_count == 0) begin
               r.status = deq_pkg::ST_EMPTY;
            end else if (op == deq_pkg::OP_POP_REAR) begin
               r.value_out = shadow_entries[shadow_rear];
               shadow_rear = shadow_rear - 1'b1;
               shadow_count--;
            end else begin
               slot = shadow_rear + 1'b1 - IDX_W'(shadow_count);
               r.value_out = shadow_entries[slot];
               shadow_count--;
            end
         end
      endcase
      r.count_after = COUNT_W'(shadow_count);
      return r;
   endfunction

   task automatic offer_item(input deq_pkg::operation_type op, input logic [31:0] v,
                             input logic typed, input deque_result_type typed_res);
      deque_result_type predicted;
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value_in  <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_operation(op, v);
      expected_q.push_back(typed ? typed_res : predicted);
      items_sent++;
   endtask

   task automatic pause(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   task automatic offer_random(input int bias);
      logic        is_pop;
      logic [31:0] v;
      int          pick;
      pick = $urandom_range(0, 99);
      case (bias)
         0: is_pop = (pick >= 75);
         1: is_pop = (pick < 75);
         default: is_pop = pick[0];
      endcase
      case ($urandom_range(0, 7))
         0: v = 32'h8000_0000;
         1: v = 32'h7fff_ffff;
         2: v = 32'h0000_0000;
         3: v = 32'hffff_ffff;
         4: v = $urandom_range(0, 15);
         default: v = $urandom;
      endcase
      offer_item(deq_pkg::operation_type'({is_pop, 1'($urandom_range(0, 1))}), v,
                 1'b0, '0);
   endtask

   task automatic run_random(input int last_item);
      int bias;
      int burst;
      while (items_sent < last_item) begin
         bias  = $urandom_range(0, 2);
         burst = $urandom_range(1, 24);
         repeat (burst) offer_random(bias);
         if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 6));
      end
   endtask

   task automatic check_result();
      deque_result_type want;
      if (expected_q.size() == 0) begin
         errors++;
         $display("%0t: result with no item outstanding: status %0d value %h count %0d",
                  $time, rsp_status, rsp_value_out, rsp_count_after);
      end else begin
         want = expected_q.pop_front();
         if (rsp_status !== want.status) begin
            errors++;
            $display("%0t: status expected %0d, actual %0d", $time, want.status, rsp_status);
         end
         if (rsp_value_out !== want.value_out) begin
            errors++;
            $display("%0t: value_out expected %h, actual %h",
                     $time, want.value_out, rsp_value_out);
         end
         if (rsp_count_after !== want.count_after) begin
            errors++;
            $display("%0t: count_after expected %0d, actual %0d",
                     $time, want.count_after, rsp_count_after);
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) check_result();
         stall_cycle <= stall_cycle + 1'b1;
         if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= 1'b1;
         end else if (holdoff_go && !holdoff_taken) begin
            hold_left     <= HOLD_CYCLES;
            holdoff_taken <= 1'b1;
            rsp_stall     <= 1'b1;
         end else begin
            if (stall_cycle[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
            case (stall_mode)
               2'd0: rsp_stall <= 1'b0;
               2'd1: rsp_stall <= ($urandom_range(0, 1) == 1);
               2'd2: rsp_stall <= (stall_cycle[2:0] >= 3'd5);
               default: rsp_stall <= ($urandom_range(0, 9) < 8);
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("double_ended_queue verification failed");
         $finish;
      end
   end

   initial begin
      deque_step_type row;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[r]) begin
         row = directed_steps[r];
         for (int k = 0; k < int'(row.reps); k++) begin
            offer_item(row.op, row.value + k, row.typed, row.res);
         end
         pause($urandom_range(0, 1));
      end

      run_random(300);

      // Hold the result side off while items keep coming so that the input backs up.
      holdoff_go <= 1'b1;
      repeat (40) offer_random(2);
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);

      run_random(ITEM_TARGET);

      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      if (errors == 0 && expected_q.size() == 0) begin
         $display("double_ended_queue verification clean");
      end else begin
         $display("double_ended_queue verification failed");
      end
      $finish;
   end

endmodule
